// File: src/tpt_pkg.sv
// Package: shared types, widths and constants for the TLB and page table translation block.
`default_nettype none

package tpt_pkg;

    // Field widths of the request and result
    localparam int VA_W   = 16;
    localparam int TIME_W = 32;
    localparam int PA_W   = 14;

    // Fixed page size and the derived address split
    localparam int PAGE_SIZE = 1024;
    localparam int OFF_W     = $clog2(PAGE_SIZE);
    localparam int RAW_W     = VA_W - OFF_W;

    // Defaults for the sizing parameters of the top level
    localparam int TLB_ENTRIES_DEF   = 8;
    localparam int FRAME_COUNT_DEF   = 16;
    localparam int VIRTUAL_PAGES_DEF = 64;

    typedef struct packed {
        logic [VA_W-1:0]   virtual_address;
        logic [TIME_W-1:0] request_time;
    } t_req;

    typedef struct packed {
        logic [PA_W-1:0] physical_address;
        logic            tlb_hit;
        logic            table_hit;
        logic            newly_loaded;
        logic            out_of_frames;
    } t_resp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic resolve;
        logic alloc;
        logic fill_next;
        logic scan_start;
        logic scan_step;
        logic fill_victim;
        logic out_direct;
        logic out_held;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic tlb_hit;
        logic tab_valid;
        logic frame_free;
        logic tlb_full;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: src/tpt_ctrl.sv
// Controller: state machine that sequences clear, lookup, victim scan and result hand-off.
`default_nettype none

module tpt_ctrl
    import tpt_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    logic miss;
    logic need_fill;

    assign miss      = !i_stat.tlb_hit;
    assign need_fill = miss && (i_stat.tab_valid || i_stat.frame_free);

    // Hold the state; reset starts the table clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                priority if (need_fill && i_stat.tlb_full) begin
                    n_state = S_SCAN;
                end else if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            S_LOOKUP: begin
                o_cmd.resolve = 1'b1;
                o_cmd.alloc   = miss && !i_stat.tab_valid && i_stat.frame_free;
                priority if (need_fill && i_stat.tlb_full) begin
                    o_cmd.scan_start = 1'b1;
                end else begin
                    o_cmd.fill_next  = need_fill;
                    o_cmd.out_direct = i_stat.out_free;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step   = !i_stat.scan_last;
                o_cmd.fill_victim = i_stat.scan_last;
            end
            S_EMIT: begin
                o_cmd.out_held = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: src/tpt_dpath.sv
// Datapath: TLB entries, page table memory, frame allocator, victim scan and result register.
`default_nettype none

module tpt_dpath
    import tpt_pkg::*;
#(
    parameter int TLB_ENTRIES   = TLB_ENTRIES_DEF,
    parameter int FRAME_COUNT   = FRAME_COUNT_DEF,
    parameter int VIRTUAL_PAGES = VIRTUAL_PAGES_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_req  i_req,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    input  wire   i_out_stall,
    output logic  o_out_valid,
    output t_resp o_out_resp
);

    localparam int TIDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TLB_ENTRIES + 1);
    localparam int FR_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int FCNT_W = $clog2(FRAME_COUNT + 1);
    localparam int PG_W   = (VIRTUAL_PAGES > 1) ? $clog2(VIRTUAL_PAGES) : 1;
    localparam int RAW_N  = 2 ** RAW_W;

    // Request registers
    logic [PG_W-1:0]   r_page;
    logic [OFF_W-1:0]  r_offset;
    logic [TIME_W-1:0] r_time;

    // TLB entries; they fill in index order, so the fill count marks the valid ones
    logic [PG_W-1:0]   r_tlb_page    [TLB_ENTRIES];
    logic [FR_W-1:0]   r_tlb_frame   [TLB_ENTRIES];
    logic [TIME_W-1:0] r_tlb_created [TLB_ENTRIES];
    logic [CNT_W-1:0]  r_tlb_cnt;

    // Page table memory: valid bit above the frame number
    logic [FR_W:0]     r_table [VIRTUAL_PAGES];
    logic [FR_W:0]     r_rd_data;
    logic [PG_W-1:0]   r_clr_addr;

    // Frames are taken lowest first and never released, so a counter tracks the next free one
    logic [FCNT_W-1:0] r_next_frame;

    // Victim scan
    logic [CNT_W-1:0]  r_probe;
    logic [TIDX_W-1:0] r_best_idx;
    logic [TIME_W-1:0] r_best_time;

    // Resolved result and frame held across the scan
    t_resp             r_res;
    logic [FR_W-1:0]   r_fill_frame;

    // Output register
    logic              r_out_valid;
    t_resp             r_out;

    logic [PG_W-1:0]   page_lut [RAW_N];
    logic [PG_W-1:0]   page_in;
    logic              hit;
    logic [FR_W-1:0]   hit_frame;
    logic              tab_valid;
    logic              frame_free;
    logic [FR_W-1:0]   res_frame;
    t_resp             res_comb;
    logic              out_free;
    logic [TIDX_W-1:0] probe_idx;
    logic [TIDX_W-1:0] fill_slot;
    logic [FR_W-1:0]   fill_frame;
    logic              fill_en;

    // Wrap the raw page number into the table range
    for (genvar g = 0; g < RAW_N; g++) begin : g_lut
        assign page_lut[g] = PG_W'(g % VIRTUAL_PAGES);
    end

    assign page_in    = page_lut[i_req.virtual_address[VA_W-1:OFF_W]];
    assign tab_valid  = r_rd_data[FR_W];
    assign frame_free = (r_next_frame != FCNT_W'(FRAME_COUNT));
    assign res_frame  = tab_valid ? r_rd_data[FR_W-1:0] : r_next_frame[FR_W-1:0];
    assign out_free   = !r_out_valid || !i_out_stall;
    assign probe_idx  = r_probe[TIDX_W-1:0];

    // Search the TLB in parallel; a page sits in at most one entry
    always_comb begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if ((CNT_W'(i) < r_tlb_cnt) && (r_tlb_page[i] == r_page)) begin
                hit       = 1'b1;
                hit_frame = hit_frame | r_tlb_frame[i];
            end
        end
    end

    // Build the result of the lookup
    always_comb begin
        res_comb = '0;
        priority if (hit) begin
            res_comb.physical_address = PA_W'({hit_frame, r_offset});
            res_comb.tlb_hit          = 1'b1;
        end else if (tab_valid) begin
            res_comb.physical_address = PA_W'({res_frame, r_offset});
            res_comb.table_hit        = 1'b1;
        end else if (frame_free) begin
            res_comb.physical_address = PA_W'({res_frame, r_offset});
            res_comb.newly_loaded     = 1'b1;
        end else begin
            res_comb.out_of_frames    = 1'b1;
        end
    end

    // Status to the controller
    always_comb begin
        o_stat            = '0;
        o_stat.clr_last   = (r_clr_addr == PG_W'(VIRTUAL_PAGES - 1));
        o_stat.tlb_hit    = hit;
        o_stat.tab_valid  = tab_valid;
        o_stat.frame_free = frame_free;
        o_stat.tlb_full   = (r_tlb_cnt == CNT_W'(TLB_ENTRIES));
        o_stat.scan_last  = (r_probe == CNT_W'(TLB_ENTRIES));
        o_stat.out_free   = out_free;
    end

    // Capture the request and read the page table entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_page    <= page_in;
            r_offset  <= i_req.virtual_address[OFF_W-1:0];
            r_time    <= i_req.request_time;
            r_rd_data <= r_table[page_in];
        end
    end

    // Write the page table: clearing sweep, or a new mapping
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_table[r_clr_addr] <= '0;
        end else if (i_cmd.alloc) begin
            r_table[r_page] <= {1'b1, r_next_frame[FR_W-1:0]};
        end
    end

    // Advance the clearing address and the frame allocator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_next_frame <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + PG_W'(1);
            end
            if (i_cmd.alloc) begin
                r_next_frame <= r_next_frame + FCNT_W'(1);
            end
        end
    end

    // Hold the resolved result and frame
    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_res        <= res_comb;
            r_fill_frame <= res_frame;
        end
    end

    // Scan the creation times for the oldest entry, lowest index on ties
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_best_idx  <= '0;
            r_best_time <= r_tlb_created[0];
            r_probe     <= CNT_W'(1);
        end else if (i_cmd.scan_step) begin
            if (r_tlb_created[probe_idx] < r_best_time) begin
                r_best_idx  <= probe_idx;
                r_best_time <= r_tlb_created[probe_idx];
            end
            r_probe <= r_probe + CNT_W'(1);
        end
    end

    // Fill a TLB entry: next free one, or the scan's victim
    assign fill_en    = i_cmd.fill_next || i_cmd.fill_victim;
    assign fill_slot  = i_cmd.fill_victim ? r_best_idx : r_tlb_cnt[TIDX_W-1:0];
    assign fill_frame = i_cmd.fill_victim ? r_fill_frame : res_frame;

    always_ff @(posedge i_clk) begin
        if (fill_en) begin
            r_tlb_page[fill_slot]    <= r_page;
            r_tlb_frame[fill_slot]   <= fill_frame;
            r_tlb_created[fill_slot] <= r_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_cnt <= '0;
        end else if (i_cmd.fill_next) begin
            r_tlb_cnt <= r_tlb_cnt + CNT_W'(1);
        end
    end

    // Load the output register; drop its valid once the result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_direct || i_cmd.out_held) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_direct) begin
            r_out <= res_comb;
        end else if (i_cmd.out_held) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_resp  = r_out;

endmodule

`default_nettype wire

// File: src/tlb_page_table_translation_top.sv
// Top level: virtual to physical translation through a TLB and a page table.
// Sequence: a request is accepted in idle and resolved in lookup. On a hit, or on a miss
//   that needs no victim, the result is loaded from lookup into the output register; on a
//   miss with a full TLB, after the one-entry-per-cycle scan for the oldest creation time.
// Flow: a new request is accepted only in idle, once the previous result has gone into the
//   output register (waiting in emit while the result side stalls); the input stalls otherwise.
// Reset: synchronous, active low; the page table is then cleared one entry per cycle,
//   all VIRTUAL_PAGES entries, with the request input stalled.
`default_nettype none

module tlb_page_table_translation_top
    import tpt_pkg::*;
#(
    parameter int TLB_ENTRIES   = TLB_ENTRIES_DEF,
    parameter int FRAME_COUNT   = FRAME_COUNT_DEF,
    parameter int VIRTUAL_PAGES = VIRTUAL_PAGES_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_stall,
    input  t_req  i_in_req,
    output logic  o_out_valid,
    input  wire   i_out_stall,
    output t_resp o_out_resp
);

    t_cmd  cmd;
    t_stat stat;

    // Sequence each request
    tpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Hold the translation state and compute results
    tpt_dpath #(
        .TLB_ENTRIES   (TLB_ENTRIES),
        .FRAME_COUNT   (FRAME_COUNT),
        .VIRTUAL_PAGES (VIRTUAL_PAGES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_resp  (o_out_resp)
    );

endmodule

`default_nettype wire
